// ===== rtl/fpis_pkg.sv =====
`default_nettype none
package fpis_pkg;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_RUN = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_tick;
    logic [31:0] task_interval;
    logic [7:0]  task_priority;
    logic        has_handler;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        task_selected;
    logic [3:0]  task_index;
    logic [31:0] idle_total;
  } out_t;

  // One table entry as held in a cell.
  typedef struct packed {
    logic [31:0] interval;
    logic [7:0]  prio;
    logic [31:0] last_run;
    logic        handler;
  } entry_t;

  // Best candidate so far, passed down the chain.
  typedef struct packed {
    logic       found;
    logic [7:0] prio;
    logic       handler;
  } cand_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/fpis_cell.sv =====
`default_nettype none
module fpis_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            active,
  input  wire logic [31:0]     now_tick,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_idx,
  input  wire fpis_pkg::entry_t wr_entry,
  input  wire logic            upd_en,
  input  wire logic [IW-1:0]   upd_idx,
  input  wire fpis_pkg::cand_t cand_in,
  input  wire logic [IW-1:0]   idx_in,
  output fpis_pkg::cand_t      cand_out,
  output logic [IW-1:0]        idx_out
);
  import fpis_pkg::*;

  entry_t      entry;
  logic [31:0] due;
  logic        ready;
  logic        take;

  assign due   = entry.last_run + entry.interval;
  assign ready = active && (due <= now_tick);
  // Strict compare keeps the earlier cell on a priority tie.
  assign take  = ready && (!cand_in.found || (entry.prio < cand_in.prio));

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      entry <= wr_entry;
    end else if (upd_en && (upd_idx == IW'(IDX))) begin
      entry.last_run <= now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
      idx_out  <= '0;
    end else if (take) begin
      cand_out.found   <= 1'b1;
      cand_out.prio    <= entry.prio;
      cand_out.handler <= entry.handler;
      idx_out          <= IW'(IDX);
    end else begin
      cand_out <= cand_in;
      idx_out  <= idx_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fixed_priority_interval_scheduler.sv =====
// Add transaction: once accepted, the result is loaded from S_ADD when the output is free.
// Run transaction: the result is loaded from S_SCAN once the scan count reaches MAX_TASKS
// and the output is free. The candidate walks the cell chain one cell per cycle.
// One transaction at a time; the next is accepted in the cycle after the result is
// loaded, even while that result still waits at the output.
// Reset (rst, synchronous): empty table, idle with zero idle time, output empty.
`default_nettype none
module fixed_priority_interval_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fpis_pkg::in_t in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fpis_pkg::out_t     out_item
);
  import fpis_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  state_t      state;
  state_t      state_next;
  in_t         req;
  logic [CW-1:0] task_count;
  logic [CW-1:0] scan_cnt;
  logic        idle_flag;
  logic [31:0] idle_start;
  logic [31:0] idle_sum;

  logic        idle_flag_next;
  logic [31:0] idle_start_next;
  logic [31:0] idle_sum_next;
  logic        in_accept;
  logic        out_free;
  logic        out_load;
  out_t        out_next;
  logic        add_wr;
  logic        upd_en;
  logic        scan_done;
  logic        table_full;
  entry_t      wr_entry;

  cand_t          cand [MAX_TASKS+1];
  logic [IW-1:0]  cidx [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] active;
  logic [IW+3:0]  idx_ext;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign scan_done  = (scan_cnt == CW'(MAX_TASKS));
  assign table_full = (task_count >= CW'(MAX_TASKS));
  assign idx_ext    = {4'b0000, cidx[MAX_TASKS]};

  assign wr_entry.interval = req.task_interval;
  assign wr_entry.prio     = req.task_priority;
  assign wr_entry.last_run = req.now_tick;
  assign wr_entry.handler  = req.has_handler;

  assign cand[0] = '0;
  assign cidx[0] = '0;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    assign active[i] = (task_count > CW'(i));
    fpis_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .active   (active[i]),
      .now_tick (req.now_tick),
      .wr_en    (add_wr),
      .wr_idx   (task_count[IW-1:0]),
      .wr_entry (wr_entry),
      .upd_en   (upd_en),
      .upd_idx  (cidx[MAX_TASKS]),
      .cand_in  (cand[i]),
      .idx_in   (cidx[i]),
      .cand_out (cand[i+1]),
      .idx_out  (cidx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_stall        = (state != S_IDLE);
    out_load        = 1'b0;
    add_wr          = 1'b0;
    upd_en          = 1'b0;
    out_next        = '0;
    idle_flag_next  = idle_flag;
    idle_start_next = idle_start;
    idle_sum_next   = idle_sum;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_item.opcode == OP_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (table_full) begin
            out_next.status = STATUS_FULL;
          end else begin
            add_wr = 1'b1;
          end
          out_next.idle_total = idle_sum;
        end
      end
      S_SCAN: begin
        if (scan_done && out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (cand[MAX_TASKS].found) begin
            if (idle_flag) begin
              idle_flag_next = 1'b0;
              idle_sum_next  = idle_sum + (req.now_tick - idle_start);
            end
            upd_en                 = cand[MAX_TASKS].handler;
            out_next.task_selected = 1'b1;
            out_next.task_index    = idx_ext[3:0];
          end else begin
            idle_start_next = req.now_tick;
            idle_flag_next  = 1'b1;
          end
          out_next.status     = STATUS_GOOD;
          out_next.idle_total = idle_sum_next;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      scan_cnt   <= '0;
      idle_flag  <= 1'b1;
      idle_start <= '0;
      idle_sum   <= '0;
    end else begin
      if (add_wr) begin
        task_count <= task_count + CW'(1);
      end
      // Restart the chain count on every new transaction.
      if (in_accept) begin
        scan_cnt <= '0;
      end else if ((state == S_SCAN) && !scan_done) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
      idle_flag  <= idle_flag_next;
      idle_start <= idle_start_next;
      idle_sum   <= idle_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= out_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    task_count <= CW'(MAX_TASKS))
    else $error("task count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    (out_load && cand[MAX_TASKS].found && (state == S_SCAN)) |->
      ((CW+IW)'(cidx[MAX_TASKS]) < (CW+IW)'(task_count)))
    else $error("selected task outside the filled table");

  assert property (@(posedge clk) disable iff (rst)
    (out_load && (state == S_ADD) && out_next.status == STATUS_FULL) |->
      (task_count == CW'(MAX_TASKS)))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) != S_IDLE))
    else $error("result loaded without a transaction in work");

endmodule
`default_nettype wire

// ===== dv/fixed_priority_interval_scheduler_tb.sv =====
`timescale 1ns / 1ps
module fixed_priority_interval_scheduler_tb;
  import fpis_pkg::*;

  localparam int TASK_SLOTS   = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 2 * (TASK_SLOTS + 2) + 4;

  // Shadow task table and idle-time bookkeeping; one expected result per transaction.
  class sched_board;
    logic [31:0] interval_tab [TASK_SLOTS];
    logic [7:0]  prio_tab [TASK_SLOTS];
    logic [31:0] last_run_tab [TASK_SLOTS];
    logic        handler_tab [TASK_SLOTS];
    int          task_count;
    logic        idle_flag;
    logic [31:0] idle_start;
    logic [31:0] idle_sum;
    out_t        pending_results[$];
    int          errors;
    int          results_seen;
    int          adds_taken;
    int          adds_refused;
    int          runs_picked;
    int          runs_idle;

    function new();
      task_count = 0;
      idle_flag  = 1'b1;
      idle_start = '0;
      idle_sum   = '0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_transaction(in_t item);
      out_t        want;
      logic [31:0] due;
      bit          found;
      int          best;
      want  = '0;
      found = 1'b0;
      best  = 0;
      if (item.opcode == OP_ADD) begin
        if (task_count < TASK_SLOTS) begin
          interval_tab[task_count] = item.task_interval;
          prio_tab[task_count]     = item.task_priority;
          last_run_tab[task_count] = item.now_tick;
          handler_tab[task_count]  = item.has_handler;
          task_count++;
          adds_taken++;
        end else begin
          want.status = STATUS_FULL;
          adds_refused++;
        end
      end else begin
        for (int i = 0; i < task_count; i++) begin
          due = last_run_tab[i] + interval_tab[i];
          // strict less-than keeps the earliest added task on a tie
          if (due <= item.now_tick && (!found || prio_tab[i] < prio_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (!found) begin
          idle_start = item.now_tick;
          idle_flag  = 1'b1;
          runs_idle++;
        end else begin
          if (idle_flag) begin
            idle_flag = 1'b0;
            idle_sum  = idle_sum + (item.now_tick - idle_start);
          end
          // a task without a handler keeps its last-run tick and stays ready
          if (handler_tab[best]) last_run_tab[best] = item.now_tick;
          want.task_selected = 1'b1;
          want.task_index    = best[3:0];
          runs_picked++;
        end
      end
      want.idle_total = idle_sum;
      pending_results.push_back(want);
    endfunction

    task check_transaction(out_t got);
      out_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0b, want %0b",
                                  results_seen, got.status, want.status));
      if (got.task_selected !== want.task_selected)
        report_mismatch($sformatf("result %0d task_selected %0b, want %0b",
                                  results_seen, got.task_selected, want.task_selected));
      if (got.task_index !== want.task_index)
        report_mismatch($sformatf("result %0d task_index %0d, want %0d",
                                  results_seen, got.task_index, want.task_index));
      if (got.idle_total !== want.idle_total)
        report_mismatch($sformatf("result %0d idle_total %0h, want %0h",
                                  results_seen, got.idle_total, want.idle_total));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  int stall_left = 0;
  int free_left  = 0;

  sched_board board = new();

  fixed_priority_interval_scheduler #(.MAX_TASKS(TASK_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: alternate runs of stalling and free flow; some free runs have no stall before them.
  always @(negedge clk) begin
    if (stall_left == 0 && free_left == 0) begin
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      free_left  = $urandom_range(1, 40);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      free_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_transaction(out_item);
  end

  function automatic in_t make_item(logic op, logic [31:0] now, logic [31:0] ivl,
                                    logic [7:0] prio, logic hnd);
    in_t item;
    item.opcode        = op;
    item.now_tick      = now;
    item.task_interval = ivl;
    item.task_priority = prio;
    item.has_handler   = hnd;
    return item;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic send_item(in_t item);
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transaction(item);
    @(negedge clk);
  endtask

  initial begin : stimulus
    in_t         item;
    logic [31:0] tick;
    int          burst_left;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty table: the first run finds nothing
    send_item(make_item(OP_RUN, 32'd5, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    send_item(make_item(OP_ADD, 32'd0, 32'd10, 8'd7, 1'b1));
    send_item(make_item(OP_ADD, 32'd0, 32'd10, 8'd7, 1'b1));
    // no handler, due only at the top tick
    send_item(make_item(OP_ADD, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0));
    // last_run + interval wraps to 0x80
    send_item(make_item(OP_ADD, 32'hFFFF_FF00, 32'h0000_0180, 8'd255, 1'b1));
    send_item(make_item(OP_ADD, 32'd0, 32'hFFFF_FFFF, 8'd1, 1'b1));
    send_item(make_item(OP_RUN, 32'd9, 32'd0, 8'd0, 1'b0));
    // equal priorities: earliest added first, then the other
    send_item(make_item(OP_RUN, 32'd10, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'd10, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'd12, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'h80, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'h80, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'h80, 32'd0, 8'd0, 1'b0));
    // the handler-less task wins twice in a row
    send_item(make_item(OP_RUN, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'hFFFF_FFFF, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'd0, 32'd0, 8'd0, 1'b0));
    send_item(make_item(OP_RUN, 32'h100, 32'd0, 8'd0, 1'b0));

    tick       = 32'h100;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 30)) @(negedge clk);
        end
      end
      burst_left--;
      // jump the time base now and then so due ticks wrap and stale tasks go unready
      if ($urandom_range(0, 99) == 0) tick = $urandom;
      item.opcode        = ($urandom_range(0, 6) == 0) ? OP_ADD : OP_RUN;
      item.task_interval = $urandom;
      item.task_priority = 8'($urandom);
      item.has_handler   = 1'($urandom);
      if ($urandom_range(0, 19) == 0) begin
        item.now_tick = $urandom;
      end else begin
        if (item.opcode == OP_RUN) tick = tick + $urandom_range(0, 40);
        item.now_tick = tick;
        if (item.opcode == OP_ADD) begin
          if ($urandom_range(0, 4) != 0) item.task_interval = $urandom_range(1, 300);
          if ($urandom_range(0, 5) != 0) item.task_priority = 8'($urandom_range(0, 15));
          item.has_handler = ($urandom_range(0, 7) != 0);
        end
      end
      send_item(item);
    end

    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_results.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived",
                                      board.pending_results.size()));

    $display("Covered %0d task adds accepted and %0d refused on a full table.",
             board.adds_taken, board.adds_refused);
    $display("Scheduling runs: %0d picked a task, %0d found none ready; %0d results checked.",
             board.runs_picked, board.runs_idle, board.results_seen);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("timeout: run did not finish, %0d results still pending",
             board.pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fpis_pkg.sv
rtl/fpis_cell.sv
rtl/fixed_priority_interval_scheduler.sv
dv/fixed_priority_interval_scheduler_tb.sv
